FILE: rtl/txpb_pkg.sv
// shared types, level codes and level selection for the tx power selector
// no dependencies; used by txpb_step and tx_power_hysteresis_boost
package txpb_pkg;

	// power levels in half-dB steps
	localparam logic [5:0] LVL_4DBM  = 6'd8;
	localparam logic [5:0] LVL_8DBM  = 6'd16;
	localparam logic [5:0] LVL_12DBM = 6'd24;
	localparam logic [5:0] LVL_14DBM = 6'd28;
	localparam logic [5:0] LVL_BOOST = 6'd33;

	// rssi thresholds in dBm with 3 dB hysteresis
	localparam int HYST_DB  = 3;
	localparam int THR_HIGH = -40;
	localparam int THR_LOW  = -60;
	localparam logic signed [7:0] RSSI_HIGH_DN = 8'(THR_HIGH - HYST_DB);
	localparam logic signed [7:0] RSSI_HIGH_UP = 8'(THR_HIGH + HYST_DB);
	localparam logic signed [7:0] RSSI_LOW_DN  = 8'(THR_LOW - HYST_DB);
	localparam logic signed [7:0] RSSI_LOW_UP  = 8'(THR_LOW + HYST_DB);

	localparam logic [15:0] DEFAULT_BOOST_MS = 16'd30000;

	// item kinds
	localparam logic [1:0] KIND_ADJUST  = 2'd0;
	localparam logic [1:0] KIND_BOOST   = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	// configuration register indexes
	localparam logic CFG_POWER_LIMITED = 1'b0;
	localparam logic CFG_BOOST_DUR     = 1'b1;

	// selector state carried between items
	typedef struct packed {
		logic [5:0]  level;
		logic [31:0] deadline;
		logic        boost_on;
	} txpb_state_t;

	// one item as held in the input register
	typedef struct packed {
		logic [1:0]        kind;
		logic signed [7:0] rssi_dbm;
		logic              link_up;
		logic [31:0]       now_ms;
	} txpb_item_t;

	// level picked from rssi with hysteresis around the current level
	function automatic logic [5:0] target_level(input logic signed [7:0] rssi,
			input logic [5:0] cur, input logic limited);
		logic [5:0] weak_lvl;
		logic [5:0] lvl;
		weak_lvl = limited ? LVL_12DBM : LVL_14DBM;
		if (cur <= LVL_4DBM) begin
			if (rssi <= RSSI_HIGH_DN) begin
				lvl = (rssi <= RSSI_LOW_UP) ? weak_lvl : LVL_8DBM;
			end else begin
				lvl = LVL_4DBM;
			end
		end else if (cur <= LVL_8DBM) begin
			if (rssi > RSSI_HIGH_UP) begin
				lvl = LVL_4DBM;
			end else if (rssi <= RSSI_LOW_DN) begin
				lvl = weak_lvl;
			end else begin
				lvl = LVL_8DBM;
			end
		end else if (rssi > RSSI_LOW_UP) begin
			lvl = (rssi > RSSI_HIGH_DN) ? LVL_4DBM : LVL_8DBM;
		end else begin
			lvl = weak_lvl;
		end
		return lvl;
	endfunction

endpackage

FILE: rtl/txpb_step.sv
// next-state logic for one item of the tx power selector
// depends on txpb_pkg
module txpb_step (
	input  txpb_pkg::txpb_item_t  item,
	input  txpb_pkg::txpb_state_t cur,
	input  logic                  power_limited,
	input  logic [15:0]           boost_duration_ms,
	output txpb_pkg::txpb_state_t nxt,
	output logic                  reprogram
);

	logic        expired;
	logic [31:0] since;
	logic [31:0] new_deadline;
	logic [5:0]  tgt;

	// wrap-safe expiry and new deadline
	assign since        = item.now_ms - cur.deadline;
	assign expired      = ~since[31];
	assign new_deadline = item.now_ms + {16'd0, boost_duration_ms};
	assign tgt          = txpb_pkg::target_level(item.rssi_dbm, cur.level, power_limited);

	// per-kind state update
	always_comb begin
		nxt       = cur;
		reprogram = 1'b0;
		unique case (item.kind)
			txpb_pkg::KIND_ADJUST: begin
				if (item.link_up && !cur.boost_on && tgt != cur.level) begin
					nxt.level = tgt;
					reprogram = 1'b1;
				end
			end
			txpb_pkg::KIND_BOOST: begin
				if (!cur.boost_on || expired) begin
					nxt.level = txpb_pkg::LVL_BOOST;
					reprogram = 1'b1;
				end
				nxt.deadline = new_deadline;
				nxt.boost_on = 1'b1;
			end
			txpb_pkg::KIND_TIMEOUT: begin
				if (cur.boost_on && expired) begin
					nxt.boost_on = 1'b0;
					nxt.level    = txpb_pkg::LVL_14DBM;
					reprogram    = 1'b1;
				end
			end
			txpb_pkg::KIND_NONE: begin
				nxt = cur;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

FILE: rtl/tx_power_hysteresis_boost.sv
// top level of the tx power selector with rssi hysteresis and timed boost
// depends on txpb_pkg and txpb_step
// items pass through the input register, then the result register
// throughput: one item per cycle while the output is not stalled, as txpb_step updates the state combinationally
// the result register frees as it is taken; input stalls only when both registers are full
// reset: asynchronous active low; level 28, no boost, limit off, boost 30000 ms
module tx_power_hysteresis_boost (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // rssi_dbm[7:0], link_up[8], now_ms[40:9], zero fill
	input  logic [1:0]  s_tuser,  // kind[1:0]
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // power_half_db[5:0], reprogram[6], boost_active[7]
);

	logic                  power_limited_q;
	logic [15:0]           boost_dur_q;
	txpb_pkg::txpb_state_t state_q;
	txpb_pkg::txpb_state_t state_nxt;
	txpb_pkg::txpb_item_t  item_s1;
	logic                  valid_s1;
	logic                  valid_s2;
	logic [7:0]            data_s2;
	logic                  reprogram;
	logic                  out_free;
	logic                  advance;

	// stage handshake
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_limited_q <= 1'b0;
			boost_dur_q     <= txpb_pkg::DEFAULT_BOOST_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				txpb_pkg::CFG_POWER_LIMITED: power_limited_q <= cfg_wdata[0];
				txpb_pkg::CFG_BOOST_DUR:     boost_dur_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind     <= s_tuser;
			item_s1.rssi_dbm <= s_tdata[7:0];
			item_s1.link_up  <= s_tdata[8];
			item_s1.now_ms   <= s_tdata[40:9];
		end
	end

	txpb_step u_step (
		.item              (item_s1),
		.cur               (state_q),
		.power_limited     (power_limited_q),
		.boost_duration_ms (boost_dur_q),
		.nxt               (state_nxt),
		.reprogram         (reprogram)
	);

	// selector state, updated as an item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.level    <= txpb_pkg::LVL_14DBM;
			state_q.deadline <= 32'd0;
			state_q.boost_on <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {state_nxt.boost_on, reprogram, state_nxt.level};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;

endmodule
